// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/abe_pkg.sv
package abe_pkg;

   // Field widths
   localparam int POS_W      = 12;
   localparam int KIND_W     = 3;
   localparam int BYTE_IDX_W = POS_W - 3;
   localparam int CNT_W      = BYTE_IDX_W + 1;

   localparam logic [7:0] BYTE_ONES = 8'hff;

   // Request codes
   localparam logic [KIND_W-1:0] KIND_TEST      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_BIT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLR_BIT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SET_RANGE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLR_RANGE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SCAN      = 3'd5;

   // Microprogram step addresses
   typedef logic [2:0] step_type;
   localparam step_type ST_CLEAR = 3'd0;
   localparam step_type ST_IDLE  = 3'd1;
   localparam step_type ST_CHECK = 3'd2;
   localparam step_type ST_ISSUE = 3'd3;
   localparam step_type ST_LOOP  = 3'd4;
   localparam step_type ST_DONE  = 3'd5;

   // Branch conditions
   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_NO_REQ   = 3'd1,
      COND_BAD      = 3'd2,
      COND_MORE     = 3'd3,
      COND_RSP_BUSY = 3'd4,
      COND_CLR_LAST = 3'd5
   } cond_type;

   // One control word per microprogram step
   typedef struct packed {
      cond_type cond;
      step_type tgt_true;
      step_type tgt_false;
      logic     act_accept;
      logic     act_check;
      logic     act_issue;
      logic     act_run;
      logic     act_finish;
      logic     act_clear;
   } ctl_type;

   // Datapath flags seen by the sequencer
   typedef struct packed {
      logic no_req;
      logic bad;
      logic more;
      logic rsp_busy;
      logic clr_last;
   } status_type;

   // Control store
   function automatic ctl_type ucode_rom(step_type step);
      ctl_type w;
      w = '0;
      case (step)
         ST_CLEAR: begin
            w.cond = COND_CLR_LAST; w.tgt_true = ST_IDLE;  w.tgt_false = ST_CLEAR;
            w.act_clear = 1'b1;
         end
         ST_IDLE: begin
            w.cond = COND_NO_REQ;   w.tgt_true = ST_IDLE;  w.tgt_false = ST_CHECK;
            w.act_accept = 1'b1;
         end
         ST_CHECK: begin
            w.cond = COND_BAD;      w.tgt_true = ST_DONE;  w.tgt_false = ST_ISSUE;
            w.act_check = 1'b1;
         end
         ST_ISSUE: begin
            w.cond = COND_ALWAYS;   w.tgt_true = ST_LOOP;  w.tgt_false = ST_LOOP;
            w.act_issue = 1'b1;
         end
         ST_LOOP: begin
            w.cond = COND_MORE;     w.tgt_true = ST_LOOP;  w.tgt_false = ST_DONE;
            w.act_run = 1'b1;
         end
         ST_DONE: begin
            w.cond = COND_RSP_BUSY; w.tgt_true = ST_DONE;  w.tgt_false = ST_IDLE;
            w.act_finish = 1'b1;
         end
         default: begin
            w.cond = COND_ALWAYS;   w.tgt_true = ST_IDLE;  w.tgt_false = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   // Index of the lowest set bit in a byte
   function automatic logic [2:0] first_one(logic [7:0] v);
      logic [2:0] idx;
      idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: hw/rtl/abe_ifs.sv
// Request channel
interface abe_req_if;
   logic                        valid;
   logic                        ready;
   logic [abe_pkg::KIND_W-1:0]  req_type;
   logic [abe_pkg::POS_W-1:0]   start_pos;
   logic [abe_pkg::POS_W-1:0]   end_pos;
   logic                        bit_value;

   modport source (output valid, req_type, start_pos, end_pos, bit_value, input ready);
   modport sink   (input valid, req_type, start_pos, end_pos, bit_value, output ready);
endinterface

// Response channel
interface abe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        tested_bit;
   logic                        found;
   logic [abe_pkg::POS_W-1:0]   found_pos;
   logic                        error;

   modport source (output valid, tested_bit, found, found_pos, error, input ready);
   modport sink   (input valid, tested_bit, found, found_pos, error, output ready);
endinterface

// File: hw/rtl/abe_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module abe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/abe_seq.sv
`include "assert_macros.svh"

// Micro-PC and control store.
module abe_seq (
   input  logic                clock,
   input  logic                reset,
   input  abe_pkg::status_type stat,
   output abe_pkg::ctl_type    ctl
);
   import abe_pkg::*;

   step_type upc_ff, upc_in;
   logic     cond_true;

   assign ctl = ucode_rom(upc_ff);

   // Branch condition select
   always_comb begin
      case (ctl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_REQ:   cond_true = stat.no_req;
         COND_BAD:      cond_true = stat.bad;
         COND_MORE:     cond_true = stat.more;
         COND_RSP_BUSY: cond_true = stat.rsp_busy;
         COND_CLR_LAST: cond_true = stat.clr_last;
         default:       cond_true = 1'b1;
      endcase
      upc_in = cond_true ? ctl.tgt_true : ctl.tgt_false;
   end

   // Reset starts with the map clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // Once the response is loaded the sequencer is back waiting for work
   `ASSERT_NEXT(a_finish_to_idle, clock, reset, ctl.act_finish && !stat.rsp_busy,
                upc_ff == ST_IDLE)

endmodule

// File: hw/rtl/abe_dp.sv
`include "assert_macros.svh"

// Request registers, byte walker, mask logic and response register.
module abe_dp #(
   parameter int MAP_BITS = 4096,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic                clock,
   input  logic                reset,
   abe_req_if.sink             req_ch,
   abe_rsp_if.source           rsp_ch,
   input  abe_pkg::ctl_type    ctl,
   output abe_pkg::status_type stat,
   output logic                ram_wr_en,
   output logic [AW-1:0]       ram_wr_addr,
   output logic [7:0]          ram_wr_data,
   output logic                ram_rd_en,
   output logic [AW-1:0]       ram_rd_addr,
   input  logic [7:0]          ram_rd_data
);
   import abe_pkg::*;

   // Request registers
   logic [KIND_W-1:0]     kind_ff;
   logic [POS_W-1:0]      start_ff;
   logic [POS_W-1:0]      end_ff;
   logic                  want_ff;

   // Walker
   logic [CNT_W-1:0]      rd_addr_ff;
   logic                  pend_ff;
   logic [BYTE_IDX_W-1:0] pend_addr_ff;
   logic [AW-1:0]         clr_addr_ff;

   // Result under construction
   logic                  res_tested_ff;
   logic                  res_found_ff;
   logic [POS_W-1:0]      res_pos_ff;
   logic                  res_err_ff;

   // Response register
   logic                  rsp_valid_ff;
   logic                  rsp_tested_ff;
   logic                  rsp_found_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic                  rsp_err_ff;

   logic                  req_fire;
   logic                  bad;
   logic [BYTE_IDX_W-1:0] last_byte;
   logic [7:0]            lo_mask, hi_mask, mask;
   logic [7:0]            hit_bits;
   logic                  is_write_op, is_set_op;
   logic                  scan_hit;
   logic                  more;
   logic                  rsp_busy;
   logic                  rsp_load;

   assign req_ch.ready = ctl.act_accept;
   assign req_fire     = req_ch.valid && ctl.act_accept;

   // Request checks; single-bit requests carry start as their end
   assign bad = (kind_ff > KIND_SCAN) || (end_ff < start_ff)
                || (32'(end_ff) >= 32'(MAP_BITS));
   assign last_byte = end_ff[POS_W-1:3];

   // Bits of the byte in flight that fall inside [start, end]
   always_comb begin
      lo_mask = (pend_addr_ff == start_ff[POS_W-1:3]) ? (BYTE_ONES << start_ff[2:0])
                                                      : BYTE_ONES;
      hi_mask = (pend_addr_ff == last_byte) ? (BYTE_ONES >> (3'd7 - end_ff[2:0]))
                                            : BYTE_ONES;
      mask    = lo_mask & hi_mask;
   end

   assign hit_bits    = (want_ff ? ram_rd_data : ~ram_rd_data) & mask;
   assign scan_hit    = ctl.act_run && pend_ff && (kind_ff == KIND_SCAN) && (|hit_bits);
   assign is_set_op   = (kind_ff == KIND_SET_BIT) || (kind_ff == KIND_SET_RANGE);
   assign is_write_op = is_set_op || (kind_ff == KIND_CLR_BIT)
                        || (kind_ff == KIND_CLR_RANGE);
   assign more        = (rd_addr_ff <= {1'b0, last_byte}) && !scan_hit;

   // Memory access: clearing pass, or reads of the span with write-back of the byte in flight
   assign ram_rd_en   = ctl.act_issue || (ctl.act_run && more);
   assign ram_rd_addr = rd_addr_ff[AW-1:0];
   assign ram_wr_en   = ctl.act_clear || (ctl.act_run && pend_ff && is_write_op);
   assign ram_wr_addr = ctl.act_clear ? clr_addr_ff : pend_addr_ff[AW-1:0];
   assign ram_wr_data = ctl.act_clear ? 8'h00
                      : (is_set_op ? (ram_rd_data | mask) : (ram_rd_data & ~mask));

   assign rsp_busy = rsp_valid_ff && !rsp_ch.ready;
   assign rsp_load = ctl.act_finish && !rsp_busy;

   always_comb begin
      stat          = '0;
      stat.no_req   = !req_ch.valid;
      stat.bad      = bad;
      stat.more     = more;
      stat.rsp_busy = rsp_busy;
      stat.clr_last = (clr_addr_ff == AW'(DEPTH - 1));
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.act_clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (ctl.act_issue) begin
            pend_ff <= 1'b1;
         end else if (ctl.act_run) begin
            pend_ff <= more;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff       <= req_ch.req_type;
         start_ff      <= req_ch.start_pos;
         end_ff        <= (req_ch.req_type <= KIND_CLR_BIT) ? req_ch.start_pos
                                                           : req_ch.end_pos;
         want_ff       <= req_ch.bit_value;
         rd_addr_ff    <= {1'b0, req_ch.start_pos[POS_W-1:3]};
         res_tested_ff <= 1'b0;
         res_found_ff  <= 1'b0;
         res_pos_ff    <= '0;
         res_err_ff    <= 1'b0;
      end
      if (ctl.act_check) begin
         res_err_ff <= bad;
      end
      if (ctl.act_issue || (ctl.act_run && more)) begin
         pend_addr_ff <= rd_addr_ff[BYTE_IDX_W-1:0];
         rd_addr_ff   <= rd_addr_ff + 1'b1;
      end
      if (ctl.act_run && pend_ff && (kind_ff == KIND_TEST)) begin
         res_tested_ff <= |(ram_rd_data & mask);
      end
      if (scan_hit) begin
         res_found_ff <= 1'b1;
         res_pos_ff   <= {pend_addr_ff, first_one(hit_bits)};
      end
      if (rsp_load) begin
         rsp_tested_ff <= res_tested_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_err_ff    <= res_err_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.tested_bit = rsp_tested_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.found_pos  = rsp_pos_ff;
   assign rsp_ch.error      = rsp_err_ff;

   // Tests and scans never touch the map
   `ASSERT_PROP(a_no_write_on_read_ops, clock, reset,
                (ctl.act_run && (kind_ff == KIND_TEST || kind_ff == KIND_SCAN))
                |-> !ram_wr_en)
   // The byte in flight always lies inside the requested byte span
   `ASSERT_PROP(a_pend_in_span, clock, reset,
                (ctl.act_run && pend_ff)
                |-> (pend_addr_ff <= last_byte && pend_addr_ff >= start_ff[POS_W-1:3]))
   // A rejected request reports nothing else
   `ASSERT_PROP(a_err_alone, clock, reset,
                (rsp_valid_ff && rsp_err_ff) |-> !(rsp_found_ff || rsp_tested_ff))

endmodule

// File: hw/rtl/allocation_bitmap_engine.sv
// Allocation bit map of MAP_BITS bits held one byte per word in an on-chip RAM,
// with test, set, clear, range set/clear and find-first scan requests. A small
// microprogram steps a byte walker over the RAM: after accept and check of a
// valid request it walks the bytes from start_pos/8 to end_pos/8 (a scan stops
// at the byte holding the first match), reading each byte and, for set and
// clear requests, writing it back modified through the RAM's separate read and
// write ports. One request is worked at a time; the next is accepted while the
// previous response waits in the output register. After reset the RAM is
// cleared one byte per cycle, all min((MAP_BITS+7)/8, 512) bytes (512 by
// default), during which no request is accepted. Rejected requests (unused
// codes, position beyond the map, end before start) leave the map as it is and
// return error with all other fields zero.
module allocation_bitmap_engine #(
   parameter int MAP_BITS = 4096
) (
   input  logic      clock,
   input  logic      reset,
   abe_req_if.sink   req_ch,
   abe_rsp_if.source rsp_ch
);
   import abe_pkg::*;

   localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
   localparam int MAX_BYTES = 1 << BYTE_IDX_W;
   localparam int DEPTH     = (MAP_BYTES < MAX_BYTES) ? MAP_BYTES : MAX_BYTES;
   localparam int AW        = $clog2(DEPTH > 1 ? DEPTH : 2);

   ctl_type    ctl;
   status_type stat;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [7:0]    ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   // Sequencer
   abe_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // Datapath
   abe_dp #(
      .MAP_BITS (MAP_BITS),
      .DEPTH    (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ctl         (ctl),
      .stat        (stat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Map storage
   abe_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
